// ===== src/tmp_pkg.sv =====
package tmp_pkg;

    // Number of servo axes handled by the block; the axis field is one bit wide.
    localparam int NUM_AXES = 2;

    // Operation carried in the op field of an input transfer.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Operations of the shared arithmetic unit: shift-and-add multiply, shift-and-subtract divide and root.
    typedef logic [1:0] t_arith_op;
    localparam t_arith_op OP_MUL  = 2'd0;
    localparam t_arith_op OP_DIV  = 2'd1;
    localparam t_arith_op OP_SQRT = 2'd2;

    // Request to the arithmetic unit. For a multiply, x[48:0] is the multiplicand and
    // y the multiplier. For a divide, x is the dividend and y[23:0] the divisor.
    // For a square root, x is the radicand.
    typedef struct packed {
        logic       start;
        t_arith_op  op;
        logic [87:0] x;
        logic [48:0] y;
    } t_arith_req;

    // Completion pulse and result: product, quotient, or root in the low 44 bits.
    typedef struct packed {
        logic        done;
        logic [97:0] res;
    } t_arith_rsp;

endpackage

// ===== src/tmp_arith.sv =====
module tmp_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tmp_pkg::t_arith_req i_req,
    output tmp_pkg::t_arith_rsp o_rsp
);
    import tmp_pkg::*;

    localparam logic [6:0] MUL_STEPS  = 7'd49;
    localparam logic [6:0] DIV_STEPS  = 7'd88;
    localparam logic [6:0] SQRT_STEPS = 7'd44;

    logic        r_busy;
    logic        r_done;
    t_arith_op   r_op;
    logic [6:0]  r_cnt;
    logic [97:0] r_acc;
    logic [45:0] r_rem;
    logic [43:0] r_root;
    logic [48:0] r_y;

    logic [49:0] mul_sum;
    logic [24:0] div_t;
    logic        div_ge;
    logic [45:0] sq_t;
    logic [45:0] sq_trial;
    logic        sq_ge;

    // One multiplier bit, one quotient bit or one root bit is settled per cycle.
    assign mul_sum  = {1'b0, r_acc[97:49]} + (r_acc[0] ? {1'b0, r_y} : 50'd0);
    assign div_t    = {r_rem[23:0], r_acc[87]};
    assign div_ge   = div_t >= {1'b0, r_y[23:0]};
    assign sq_t     = {r_rem[43:0], r_acc[87:86]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_rem  <= 46'd0;
            r_root <= 44'd0;
            case (i_req.op)
                OP_MUL: begin
                    r_y   <= i_req.x[48:0];
                    r_acc <= {49'd0, i_req.y};
                    r_cnt <= MUL_STEPS;
                end
                OP_DIV: begin
                    r_y   <= i_req.y;
                    r_acc <= {10'd0, i_req.x};
                    r_cnt <= DIV_STEPS;
                end
                default: begin
                    r_y   <= i_req.y;
                    r_acc <= {10'd0, i_req.x};
                    r_cnt <= SQRT_STEPS;
                end
            endcase
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            case (r_op)
                OP_MUL: begin
                    r_acc <= {mul_sum, r_acc[48:1]};
                end
                OP_DIV: begin
                    r_acc <= {r_acc[96:0], div_ge};
                    r_rem <= {21'd0, div_ge ? div_t - {1'b0, r_y[23:0]} : div_t};
                end
                default: begin
                    r_acc  <= {r_acc[95:0], 2'b00};
                    r_rem  <= sq_ge ? sq_t - sq_trial : sq_t;
                    r_root <= {r_root[42:0], sq_ge};
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = (r_op == OP_SQRT) ? {54'd0, r_root} : r_acc;

endmodule

// ===== src/trapezoidal_motion_profile_top.sv =====
// Channel  | Valid    | Stall    | Payload
// ---------+----------+----------+-------------------------------------------------------
// input    | i_valid  | o_stall  | i_op, i_axis, i_distance, i_peak_velocity,
//          |          |          | i_acceleration
// output   | o_valid  | i_stall  | o_step_delta, o_move_done, o_axis_busy, o_start_rejected
//
// One item is worked on at a time. A start plans a trapezoid or a triangle, or is rejected;
// a tick works out a step while decelerating, accelerating or cruising, ends the move, or
// answers with no step on an idle axis. The multiplies, divides and square roots are done
// by the shared arithmetic unit, which settles one bit per cycle. Reset is synchronous and
// active low; it idles every axis and empties the output register. The output register
// lets a new item be taken while a result waits; a finished item waits in its last state
// until the output register is free.
module trapezoidal_motion_profile_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic               i_axis,
    input  logic signed [31:0] i_distance,
    input  logic [23:0]        i_peak_velocity,
    input  logic [23:0]        i_acceleration,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [9:0]  o_step_delta,
    output logic               o_move_done,
    output logic               o_axis_busy,
    output logic               o_start_rejected
);
    import tmp_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RT   = 5'd1;
    localparam logic [4:0] ST_VV   = 5'd2;
    localparam logic [4:0] ST_RD   = 5'd3;
    localparam logic [4:0] ST_CHK  = 5'd4;
    localparam logic [4:0] ST_Q    = 5'd5;
    localparam logic [4:0] ST_SQ   = 5'd6;
    localparam logic [4:0] ST_VN   = 5'd7;
    localparam logic [4:0] ST_CT   = 5'd8;
    localparam logic [4:0] ST_TOT  = 5'd9;
    localparam logic [4:0] ST_T0   = 5'd10;
    localparam logic [4:0] ST_T1   = 5'd11;
    localparam logic [4:0] ST_T2   = 5'd12;
    localparam logic [4:0] ST_VT   = 5'd13;
    localparam logic [4:0] ST_HA   = 5'd14;
    localparam logic [4:0] ST_HB   = 5'd15;
    localparam logic [4:0] ST_X    = 5'd16;
    localparam logic [4:0] ST_STEP = 5'd17;
    localparam logic [4:0] ST_FIN  = 5'd18;

    localparam logic [1:0] PH_ACC = 2'd0;
    localparam logic [1:0] PH_CRU = 2'd1;
    localparam logic [1:0] PH_DEC = 2'd2;

    // Terms are clamped at two to the power sixty.
    function automatic logic [60:0] sat60(input logic [81:0] val);
        logic over;
        begin
            over = (val[81:61] != 21'd0) || (val[60] && (val[59:0] != 60'd0));
            return over ? {1'b1, 60'd0} : val[60:0];
        end
    endfunction

    // Control.
    logic [4:0]  r_state, n_state;
    logic        r_issue;
    logic [1:0]  r_phase;
    logic        r_tri;

    // Item being worked on.
    logic        r_ax;
    logic        r_neg;
    logic [31:0] r_d;
    logic [23:0] r_v;
    logic [23:0] r_a;

    // Working values of the planner and of a tick.
    logic [47:0] r_rt;
    logic [55:0] r_rd;
    logic [47:0] r_cd;
    logic [47:0] r_ct;
    logic [87:0] r_wide;
    logic [32:0] r_e;
    logic [48:0] r_rtct;
    logic signed [49:0] r_dt;
    logic [48:0] r_m;
    logic [48:0] r_t;
    logic signed [63:0] r_pos;

    // Result waiting for the output register.
    logic [9:0]  r_res_step;
    logic        r_res_done;
    logic        r_res_busy;
    logic        r_res_rej;

    // Output register.
    logic        r_ovalid;
    logic [9:0]  r_o_step;
    logic        r_o_done;
    logic        r_o_busy;
    logic        r_o_rej;

    // Per-axis move state.
    logic        r_act  [NUM_AXES];
    logic        r_mneg [NUM_AXES];
    logic [23:0] r_pv   [NUM_AXES];
    logic [23:0] r_aa   [NUM_AXES];
    logic [47:0] r_rt_a [NUM_AXES];
    logic [47:0] r_rd_a [NUM_AXES];
    logic [47:0] r_ct_a [NUM_AXES];
    logic [47:0] r_cd_a [NUM_AXES];
    logic [32:0] r_tot_a[NUM_AXES];
    logic [32:0] r_el_a [NUM_AXES];
    logic [31:0] r_ip_a [NUM_AXES];

    t_arith_req req;
    t_arith_rsp rsp;

    tmp_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    logic        in_neg;
    logic [31:0] in_mag;
    logic        in_bad;
    logic        chk_tri;
    logic [49:0] tot_sum;
    logic [32:0] tot_val;
    logic [48:0] ef;
    logic        t1_acc, t1_cru, t1_dec;
    logic [49:0] dt_neg;
    logic [60:0] vt;
    logic [60:0] hterm;
    logic [63:0] x_abs;
    logic [47:0] step_mag;
    logic [8:0]  step_sat;
    logic [9:0]  step_val;
    logic [31:0] ax_ip;

    // A negative distance is planned on its magnitude; the most negative value stays as is.
    assign in_neg  = i_distance[31];
    assign in_mag  = in_neg ? (~i_distance) + 32'd1 : i_distance;
    assign in_bad  = (i_peak_velocity == 24'd0) || (i_acceleration == 24'd0);

    // The ramps overlap when twice the ramp distance exceeds the whole distance.
    assign chk_tri = {r_rd, 1'b0} > {9'd0, r_d, 16'd0};
    assign tot_sum = {1'b0, r_rt, 1'b0} + {2'b00, r_ct} + {33'd0, 1'b1, 16'd0};
    assign tot_val = tot_sum[49] ? {33{1'b1}} : tot_sum[48:16];

    // Phase of the tick: accelerating, cruising, decelerating or finished.
    assign ef      = {r_e, 16'd0};
    assign t1_acc  = r_e < {1'b0, r_rt_a[r_ax][47:16]};
    assign t1_cru  = r_e < r_rtct[48:16];
    assign t1_dec  = r_e < r_tot_a[r_ax];
    assign dt_neg  = -r_dt;

    assign vt      = sat60(rsp.res[97:16]);
    assign hterm   = sat60({1'b0, rsp.res[97:17]});

    // Round to the nearest count, truncating toward zero, and clamp the step.
    assign x_abs    = r_pos[63] ? -r_pos : r_pos;
    assign step_mag = x_abs[63:16];
    assign step_sat = (step_mag > 48'd256) ? 9'd256 : step_mag[8:0];
    assign step_val = r_pos[63] ? -{1'b0, step_sat} : {1'b0, step_sat};
    assign ax_ip    = r_ip_a[r_ax];

    // Operands for the arithmetic unit in each computing state.
    always_comb begin
        req.start = 1'b0;
        req.op    = OP_MUL;
        req.x     = 88'd0;
        req.y     = 49'd0;
        case (r_state)
            ST_RT: begin
                req.start = r_issue;
                req.op    = OP_DIV;
                req.x     = {40'd0, r_v, 24'd0};
                req.y     = {25'd0, r_a};
            end
            ST_VV: begin
                req.start = r_issue;
                req.op    = OP_MUL;
                req.x     = {64'd0, r_v};
                req.y     = {25'd0, r_v};
            end
            ST_RD: begin
                req.start = r_issue;
                req.op    = OP_DIV;
                req.x     = {33'd0, r_wide[47:0], 7'd0};
                req.y     = {25'd0, r_a};
            end
            ST_Q: begin
                req.start = r_issue;
                req.op    = OP_DIV;
                req.x     = {r_d, 56'd0};
                req.y     = {25'd0, r_a};
            end
            ST_SQ: begin
                req.start = r_issue;
                req.op    = OP_SQRT;
                req.x     = r_wide;
            end
            ST_VN: begin
                req.start = r_issue;
                req.op    = OP_MUL;
                req.x     = {40'd0, r_rt};
                req.y     = {25'd0, r_a};
            end
            ST_CT: begin
                req.start = r_issue;
                req.op    = OP_DIV;
                req.x     = {24'd0, r_cd, 16'd0};
                req.y     = {25'd0, r_v};
            end
            ST_VT: begin
                req.start = r_issue;
                req.op    = OP_MUL;
                req.x     = {39'd0, r_m};
                req.y     = {25'd0, r_pv[r_ax]};
            end
            ST_HA: begin
                req.start = r_issue;
                req.op    = OP_MUL;
                req.x     = {39'd0, r_m};
                req.y     = {25'd0, r_aa[r_ax]};
            end
            ST_HB: begin
                req.start = r_issue;
                req.op    = OP_MUL;
                req.x     = {39'd0, r_t};
                req.y     = r_m;
            end
            default: begin
                req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_START) begin
                        n_state = in_bad ? ST_FIN : ST_RT;
                    end else begin
                        n_state = r_act[i_axis] ? ST_T0 : ST_FIN;
                    end
                end
            end
            ST_RT:   if (rsp.done) n_state = ST_VV;
            ST_VV:   if (rsp.done) n_state = ST_RD;
            ST_RD:   if (rsp.done) n_state = ST_CHK;
            ST_CHK: begin
                if (chk_tri && !r_tri) begin
                    n_state = ST_Q;
                end else begin
                    n_state = (r_v != 24'd0) ? ST_CT : ST_TOT;
                end
            end
            ST_Q:    if (rsp.done) n_state = ST_SQ;
            ST_SQ:   if (rsp.done) n_state = ST_VN;
            ST_VN:   if (rsp.done) n_state = ST_VV;
            ST_CT:   if (rsp.done) n_state = ST_TOT;
            ST_TOT:  n_state = ST_FIN;
            ST_T0:   n_state = ST_T1;
            ST_T1:   n_state = (t1_acc || t1_cru || t1_dec) ? ST_T2 : ST_FIN;
            ST_T2:   n_state = (r_phase == PH_ACC) ? ST_HA : ST_VT;
            ST_VT: begin
                if (rsp.done) n_state = (r_phase == PH_CRU) ? ST_X : ST_HA;
            end
            ST_HA:   if (rsp.done) n_state = ST_HB;
            ST_HB:   if (rsp.done) n_state = ST_X;
            ST_X:    n_state = ST_STEP;
            ST_STEP: n_state = ST_FIN;
            ST_FIN:  if (!r_ovalid || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state and per-axis flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issue  <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_act[i]  <= 1'b0;
                r_mneg[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_issue <= (n_state != r_state);
            if (r_state == ST_FIN && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && i_op == OP_START) r_act[i_axis] <= 1'b0;
                end
                ST_TOT: begin
                    r_act[r_ax]  <= 1'b1;
                    r_mneg[r_ax] <= r_neg;
                end
                ST_T1: begin
                    if (!(t1_acc || t1_cru || t1_dec)) r_act[r_ax] <= 1'b0;
                end
                default: begin
                    r_act[r_ax] <= r_act[r_ax];
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_ax       <= i_axis;
                    r_neg      <= in_neg;
                    r_d        <= in_mag;
                    r_v        <= i_peak_velocity;
                    r_a        <= i_acceleration;
                    r_tri      <= 1'b0;
                    r_res_step <= 10'd0;
                    r_res_done <= 1'b0;
                    r_res_busy <= 1'b0;
                    r_res_rej  <= (i_op == OP_START) && in_bad;
                end
            end
            ST_RT:  if (rsp.done) r_rt <= rsp.res[47:0];
            ST_VV:  if (rsp.done) r_wide <= {40'd0, rsp.res[47:0]};
            ST_RD:  if (rsp.done) r_rd <= rsp.res[55:0];
            ST_CHK: begin
                r_cd <= chk_tri ? 48'd0 : {r_d, 16'd0} - {r_rd[46:0], 1'b0};
                r_ct <= 48'd0;
            end
            ST_Q:   if (rsp.done) r_wide <= rsp.res[87:0];
            ST_SQ:  if (rsp.done) r_rt <= {4'd0, rsp.res[43:0]};
            ST_VN: begin
                if (rsp.done) begin
                    r_v   <= rsp.res[47:24];
                    r_tri <= 1'b1;
                end
            end
            ST_CT: begin
                if (rsp.done) begin
                    r_ct <= (rsp.res[63:48] != 16'd0) ? {48{1'b1}} : rsp.res[47:0];
                end
            end
            ST_TOT: begin
                r_pv[r_ax]    <= r_v;
                r_aa[r_ax]    <= r_a;
                r_rt_a[r_ax]  <= r_rt;
                r_rd_a[r_ax]  <= r_rd[47:0];
                r_ct_a[r_ax]  <= r_ct;
                r_cd_a[r_ax]  <= r_cd;
                r_tot_a[r_ax] <= tot_val;
                r_el_a[r_ax]  <= 33'd0;
                r_ip_a[r_ax]  <= 32'd0;
                r_res_busy    <= 1'b1;
            end
            ST_T0: begin
                r_e    <= (r_el_a[r_ax] == {33{1'b1}}) ? r_el_a[r_ax]
                                                       : r_el_a[r_ax] + 33'd1;
                r_rtct <= {1'b0, r_rt_a[r_ax]} + {1'b0, r_ct_a[r_ax]};
            end
            ST_T1: begin
                r_el_a[r_ax] <= r_e;
                if (t1_acc) begin
                    r_phase <= PH_ACC;
                    r_dt    <= {1'b0, ef};
                end else if (t1_cru) begin
                    r_phase <= PH_CRU;
                    r_dt    <= {1'b0, ef} - {2'b00, r_rt_a[r_ax]};
                end else begin
                    r_phase <= PH_DEC;
                    r_dt    <= {1'b0, ef} - {1'b0, r_rtct};
                end
                r_res_done <= !(t1_acc || t1_cru || t1_dec);
            end
            ST_T2: begin
                r_m <= r_dt[49] ? dt_neg[48:0] : r_dt[48:0];
                case (r_phase)
                    PH_ACC:  r_pos <= 64'sd0;
                    PH_CRU:  r_pos <= {16'd0, r_rd_a[r_ax]};
                    default: r_pos <= {15'd0, {1'b0, r_rd_a[r_ax]} + {1'b0, r_cd_a[r_ax]}};
                endcase
            end
            ST_VT: begin
                if (rsp.done) begin
                    r_pos <= r_dt[49] ? r_pos - {3'd0, vt} : r_pos + {3'd0, vt};
                end
            end
            ST_HA:  if (rsp.done) r_t <= rsp.res[72:24];
            ST_HB: begin
                if (rsp.done) begin
                    r_pos <= (r_phase == PH_ACC) ? {3'd0, hterm} : r_pos - {3'd0, hterm};
                end
            end
            ST_X: begin
                r_pos <= r_pos - {{16{ax_ip[31]}}, ax_ip, 16'd0} + 64'sd32768;
            end
            ST_STEP: begin
                r_ip_a[r_ax] <= ax_ip + {{22{step_val[9]}}, step_val};
                r_res_step   <= r_mneg[r_ax] ? -step_val : step_val;
                r_res_busy   <= 1'b1;
            end
            ST_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    r_o_step <= r_res_step;
                    r_o_done <= r_res_done;
                    r_o_busy <= r_res_busy;
                    r_o_rej  <= r_res_rej;
                end
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_stall          = (r_state != ST_IDLE);
    assign o_valid          = r_ovalid;
    assign o_step_delta     = r_o_step;
    assign o_move_done      = r_o_done;
    assign o_axis_busy      = r_o_busy;
    assign o_start_rejected = r_o_rej;

endmodule

// ===== sim/trapezoidal_motion_profile_top_tb.sv =====
module trapezoidal_motion_profile_top_tb;
    import tmp_pkg::*;

    // Fixed-point formats of the profile arithmetic.
    localparam int FRAC = 16;
    localparam int VFRAC = 16;
    localparam int AFRAC = 24;
    localparam logic [63:0] TERM_SAT = 64'd1 << 60;
    localparam logic [63:0] TICK_SAT = (64'd1 << 33) - 1;
    localparam logic [63:0] TIME_SAT = (64'd1 << (32 + FRAC)) - 1;
    localparam int STEP_SAT = 256;

    typedef struct {
        logic               op;
        logic               axis;
        logic signed [31:0] distance;
        logic [23:0]        peak_velocity;
        logic [23:0]        acceleration;
        bit                 drain_first; // sender holds off until every result is back
    } move_cmd_t;

    typedef struct {
        logic signed [9:0] step_delta;
        logic              move_done;
        logic              axis_busy;
        logic              start_rejected;
    } servo_out_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_op = 1'b0;
    logic               i_axis = 1'b0;
    logic signed [31:0] i_distance = '0;
    logic [23:0]        i_peak_velocity = '0;
    logic [23:0]        i_acceleration = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [9:0]  o_step_delta;
    logic               o_move_done;
    logic               o_axis_busy;
    logic               o_start_rejected;

    trapezoidal_motion_profile_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_axis(i_axis), .i_distance(i_distance),
        .i_peak_velocity(i_peak_velocity), .i_acceleration(i_acceleration),
        .o_valid(o_valid), .i_stall(i_stall), .o_step_delta(o_step_delta),
        .o_move_done(o_move_done), .o_axis_busy(o_axis_busy),
        .o_start_rejected(o_start_rejected)
    );

    always #2 i_clk = ~i_clk;

    move_cmd_t  cmd_queue[$];
    servo_out_t expected_steps[$];
    int         error_count = 0;
    int         issued_count = 0;
    bit         cmd_taken = 1'b0;
    bit         calm_phase = 1'b0;

    // Private copy of the per-axis profile state.
    bit          ax_active[2];
    bit          ax_negative[2];
    logic [63:0] ax_velocity[2];
    logic [63:0] ax_accel[2];
    logic [63:0] ax_ramp_t[2];
    logic [63:0] ax_ramp_d[2];
    logic [63:0] ax_cruise_t[2];
    logic [63:0] ax_cruise_d[2];
    logic [63:0] ax_total[2];
    logic [63:0] ax_elapsed[2];
    logic [31:0] ax_issued[2];

    // Product shifted right and clamped to the intermediate term limit.
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> sh;
        return (p > 128'(TERM_SAT)) ? TERM_SAT : p[63:0];
    endfunction

    function automatic logic [63:0] floor_root(logic [127:0] q);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= q) r = c;
        end
        return r;
    endfunction

    // Ramp distance v^2/(2a) with F fraction bits.
    function automatic logic [63:0] ramp_length(logic [63:0] v, logic [63:0] a);
        logic [127:0] p;
        p = (128'(v * v) << (FRAC + AFRAC)) / 128'(a);
        p = p >> (2 * VFRAC + 1);
        return p[63:0];
    endfunction

    function automatic logic [63:0] half_at_sq(logic [63:0] m, logic [63:0] a);
        return scaled_product(scaled_product(m, a, AFRAC), m, FRAC + 1);
    endfunction

    function automatic longint cruise_term(longint dt, logic [63:0] v);
        if (dt < 0) return -longint'(scaled_product(64'(-dt), v, VFRAC));
        return longint'(scaled_product(64'(dt), v, VFRAC));
    endfunction

    // Plans a move on one axis: ramp, cruise and total tick count.
    task automatic plan_profile(int ax, logic [63:0] d, logic [63:0] v, logic [63:0] a);
        logic [63:0]  df;
        logic [63:0]  rt;
        logic [63:0]  rd;
        logic [63:0]  cd;
        logic [63:0]  ct;
        logic [63:0]  tot;
        logic [127:0] q;
        df = d << FRAC;
        rt = (v << (AFRAC - VFRAC + FRAC)) / a;
        rd = ramp_length(v, a);
        if (2 * rd > df) begin
            // Ramps would overlap, so the move becomes a triangle.
            q = (128'(d) << (AFRAC + 2 * FRAC)) / 128'(a);
            rt = floor_root(q);
            v = scaled_product(rt, a, FRAC + AFRAC - VFRAC);
            rd = ramp_length(v, a);
        end
        cd = (2 * rd > df) ? 64'd0 : df - 2 * rd;
        if (v != 0) begin
            q = (128'(cd) << VFRAC) / 128'(v);
            ct = (q > 128'(TIME_SAT)) ? TIME_SAT : q[63:0];
        end else begin
            ct = '0;
        end
        tot = (2 * rt + ct + (64'd1 << FRAC)) >> FRAC;
        if (tot > TICK_SAT) tot = TICK_SAT;
        ax_velocity[ax] = {40'd0, v[23:0]};
        ax_accel[ax] = a;
        ax_ramp_t[ax] = rt;
        ax_ramp_d[ax] = rd;
        ax_cruise_t[ax] = ct;
        ax_cruise_d[ax] = cd;
        ax_total[ax] = tot;
        ax_elapsed[ax] = '0;
        ax_issued[ax] = '0;
        ax_active[ax] = 1'b1;
    endtask

    // Works out the result of one accepted transfer and updates the axis state.
    task automatic predict_servo(move_cmd_t c, output servo_out_t r);
        int          ax;
        logic [63:0] d;
        logic [63:0] e;
        logic [63:0] rt;
        logic [63:0] ct;
        logic [63:0] m;
        longint      ef;
        longint      pos;
        longint      dt;
        longint      prev;
        longint      x;
        longint      step;
        ax = c.axis;
        r = '{default: '0};
        if (c.op == OP_START) begin
            d = c.distance[31] ? 64'(-64'(signed'(c.distance))) : 64'(c.distance);
            ax_active[ax] = 1'b0;
            if (c.peak_velocity == 0 || c.acceleration == 0) begin
                r.start_rejected = 1'b1;
            end else begin
                ax_negative[ax] = c.distance[31];
                plan_profile(ax, d, 64'(c.peak_velocity), 64'(c.acceleration));
            end
            r.axis_busy = ax_active[ax];
            return;
        end
        if (!ax_active[ax]) return;
        e = ax_elapsed[ax] + 1;
        if (e > TICK_SAT) e = TICK_SAT;
        ax_elapsed[ax] = e;
        rt = ax_ramp_t[ax];
        ct = ax_cruise_t[ax];
        ef = longint'(e << FRAC);
        if (e < (rt >> FRAC)) begin
            pos = longint'(half_at_sq(64'(ef), ax_accel[ax]));
        end else if (e < ((rt + ct) >> FRAC)) begin
            pos = longint'(ax_ramp_d[ax]) + cruise_term(ef - longint'(rt), ax_velocity[ax]);
        end else if (e < ax_total[ax]) begin
            dt = ef - longint'(rt) - longint'(ct);
            m = (dt < 0) ? 64'(-dt) : 64'(dt);
            pos = longint'(ax_ramp_d[ax]) + longint'(ax_cruise_d[ax])
                + cruise_term(dt, ax_velocity[ax]) - longint'(half_at_sq(m, ax_accel[ax]));
        end else begin
            ax_active[ax] = 1'b0;
            r.move_done = 1'b1;
            return;
        end
        prev = longint'(signed'(ax_issued[ax]));
        x = pos - prev * (longint'(1) << FRAC) + (longint'(1) << (FRAC - 1));
        step = (x >= 0) ? (x >>> FRAC) : -((-x) >>> FRAC);
        if (step > STEP_SAT) step = STEP_SAT;
        if (step < -STEP_SAT) step = -STEP_SAT;
        ax_issued[ax] = ax_issued[ax] + 32'(step);
        if (ax_negative[ax]) step = -step;
        r.step_delta = 10'(step);
        r.axis_busy = 1'b1;
    endtask

    function automatic move_cmd_t start_cmd(logic ax, logic signed [31:0] d,
                                            logic [23:0] v, logic [23:0] a);
        move_cmd_t c;
        c = '{op: OP_START, axis: ax, distance: d, peak_velocity: v, acceleration: a,
              drain_first: 1'b0};
        return c;
    endfunction

    function automatic move_cmd_t tick_cmd(logic ax);
        move_cmd_t c;
        // The start-only fields carry junk on ticks; the block must ignore them.
        c = '{op: OP_TICK, axis: ax, distance: $urandom, peak_velocity: 24'($urandom),
              acceleration: 24'($urandom), drain_first: 1'b0};
        return c;
    endfunction

    // Monitor: results are checked, and a transfer seen at the rising edge is retired at the next falling edge.
    always @(posedge i_clk) begin
        servo_out_t r;
        servo_out_t want;
        move_cmd_t  c;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_steps.size() == 0) begin
                $display("%0t: result with nothing expected: step %0d done %0b busy %0b rej %0b",
                         $time, o_step_delta, o_move_done, o_axis_busy, o_start_rejected);
                error_count++;
            end else begin
                want = expected_steps.pop_front();
                if (o_step_delta !== want.step_delta || o_move_done !== want.move_done ||
                    o_axis_busy !== want.axis_busy ||
                    o_start_rejected !== want.start_rejected) begin
                    $display("%0t: expected step %0d done %0b busy %0b rej %0b, got step %0d done %0b busy %0b rej %0b",
                             $time, want.step_delta, want.move_done, want.axis_busy,
                             want.start_rejected, o_step_delta, o_move_done, o_axis_busy,
                             o_start_rejected);
                    error_count++;
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            c = '{op: i_op, axis: i_axis, distance: i_distance, peak_velocity: i_peak_velocity,
                  acceleration: i_acceleration, drain_first: 1'b0};
            predict_servo(c, r);
            expected_steps.push_back(r);
            cmd_taken = 1'b1;
        end
    end

    // Driver: valid is held with a steady payload until the transfer happens.
    always @(negedge i_clk) begin
        move_cmd_t c;
        bit        next_valid;
        next_valid = i_valid;
        if (cmd_taken) begin
            cmd_taken = 1'b0;
            void'(cmd_queue.pop_front());
            issued_count++;
            next_valid = 1'b0;
        end
        if (i_rst_n && !next_valid && cmd_queue.size() != 0) begin
            c = cmd_queue[0];
            if (c.drain_first && expected_steps.size() != 0) begin
                next_valid = 1'b0;
            end else if (calm_phase || $urandom_range(99) >= 12) begin
                next_valid = 1'b1;
                i_op <= c.op;
                i_axis <= c.axis;
                i_distance <= c.distance;
                i_peak_velocity <= c.peak_velocity;
                i_acceleration <= c.acceleration;
            end
        end
        i_valid <= next_valid;
        i_stall <= i_rst_n && !calm_phase && ($urandom_range(99) < 12);
    end

    // Phase of quiet handshakes in the middle of the random part.
    always @(negedge i_clk) begin
        calm_phase <= (issued_count >= 300 && issued_count < 500);
    end

    initial begin
        move_cmd_t c;
        int        ax;
        int        n;
        bit        drain_placed;
        drain_placed = 1'b0;
        for (int i = 0; i < 2; i++) begin
            ax_active[i] = 0; ax_negative[i] = 0; ax_velocity[i] = 0; ax_accel[i] = 0;
            ax_ramp_t[i] = 0; ax_ramp_d[i] = 0; ax_cruise_t[i] = 0; ax_cruise_d[i] = 0;
            ax_total[i] = 0; ax_elapsed[i] = 0; ax_issued[i] = 0;
        end

        // Directed part: idle ticks, rejected starts, extremes and full moves.
        cmd_queue.push_back(tick_cmd(1'b0));
        cmd_queue.push_back(start_cmd(1'b0, 32'sd100, 24'd0, 24'd100000));
        cmd_queue.push_back(start_cmd(1'b1, 32'sd100, 24'd65536, 24'd0));
        cmd_queue.push_back(start_cmd(1'b0, 32'sd40, 24'h040000, 24'h400000));
        for (int i = 0; i < 6; i++) cmd_queue.push_back(tick_cmd(1'b0));
        // Rejected start cancels the running move.
        cmd_queue.push_back(start_cmd(1'b0, -32'sd40, 24'hFFFFFF, 24'd0));
        cmd_queue.push_back(tick_cmd(1'b0));
        // Most negative distance with the largest velocity and acceleration: large steps.
        cmd_queue.push_back(start_cmd(1'b1, 32'sh80000000, 24'hFFFFFF, 24'hFFFFFF));
        for (int i = 0; i < 3; i++) cmd_queue.push_back(tick_cmd(1'b1));
        // Zero distance, then a new move that replaces it while busy.
        cmd_queue.push_back(start_cmd(1'b0, 32'sd0, 24'd1, 24'd1));
        cmd_queue.push_back(start_cmd(1'b0, 32'sh7FFFFFFF, 24'd1, 24'd1));
        cmd_queue.push_back(tick_cmd(1'b0));
        // Tiny velocity with a short move: the ramp distance rounds to zero.
        cmd_queue.push_back(start_cmd(1'b1, 32'sd1, 24'd1, 24'hFFFFFF));
        cmd_queue.push_back(tick_cmd(1'b1));
        cmd_queue.push_back(tick_cmd(1'b1));
        cmd_queue.push_back(tick_cmd(1'b1));

        // Random part: mostly well-formed moves run through, with noise in between.
        while (cmd_queue.size() < 1020) begin
            if ($urandom_range(99) < 85) begin
                ax = $urandom_range(1);
                c = start_cmd(ax, $signed(32'($urandom_range(3000))) *
                              ($urandom_range(1) ? -1 : 1),
                              24'($urandom_range(16 << 16, 1 << 12)),
                              24'($urandom_range(24'hFFFFFF, 1 << 21)));
                if (!drain_placed && cmd_queue.size() > 600) begin
                    c.drain_first = 1'b1;
                    drain_placed = 1'b1;
                end
                cmd_queue.push_back(c);
                n = $urandom_range(40, 3);
                for (int i = 0; i < n; i++)
                    cmd_queue.push_back(tick_cmd(($urandom_range(99) < 80) ? ax : !ax));
            end else begin
                c = '{op: 1'($urandom), axis: 1'($urandom), distance: $urandom,
                      peak_velocity: 24'($urandom), acceleration: 24'($urandom),
                      drain_first: 1'b0};
                if ($urandom_range(9) == 0) c.peak_velocity = '0;
                if ($urandom_range(9) == 0) c.acceleration = '0;
                cmd_queue.push_back(c);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (cmd_queue.size() == 0 && expected_steps.size() == 0);
        // Long enough for any late extra result to show up.
        repeat (1000) @(posedge i_clk);
        if (error_count == 0 && expected_steps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== trapezoidal_motion_profile_top.f =====
src/tmp_pkg.sv
src/tmp_arith.sv
src/trapezoidal_motion_profile_top.sv
sim/trapezoidal_motion_profile_top_tb.sv
